// ----- rtl/tensor_set_product_split_check_assert.svh -----
// ----------------------------------------------------------------------------
// tensor_set_product_split_check assertion macros
// Clocked on clk, disabled during rst. Empty bodies for synthesis.
// ----------------------------------------------------------------------------
`ifndef TENSOR_SET_PRODUCT_SPLIT_CHECK_ASSERT_SVH
`define TENSOR_SET_PRODUCT_SPLIT_CHECK_ASSERT_SVH

`ifndef SYNTHESIS

`define TSPSC_ASSERT_HOLD(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define TSPSC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define TSPSC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TSPSC_ASSERT_HOLD(label, cond, msg)
`define TSPSC_ASSERT_IMP(label, ante, cons, msg)
`define TSPSC_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// ----- rtl/tspsc_pkg.sv -----
// ----------------------------------------------------------------------------
// tspsc_pkg
// Shared widths, codes and sequencer states of the tensor set product block.
// ----------------------------------------------------------------------------
package tspsc_pkg;

  // defaults for the top-level parameters
  localparam int MAX_RANK_DEF   = 64;
  localparam int VALUE_BITS_DEF = 8;

  // fixed field widths
  localparam int IDX_FW     = 6;
  localparam int ENTRY_W    = 8;
  localparam int MASK_W     = 64;
  localparam int PRODUCT_W  = 8;
  localparam int RANK_REG_W = 7;

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // register file
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_RANK = '0;
  localparam logic [RANK_REG_W-1:0] RESET_RANK = 7'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR_MERGE,
    ST_ACC,
    ST_DRAIN,
    ST_SPLIT,
    ST_SPLIT_END,
    ST_OUT
  } state_t;

endpackage

// ----- rtl/tspsc_if.sv -----
// ----------------------------------------------------------------------------
// tspsc_if
// Request and result channels: valid/ready handshake plus payload.
// ----------------------------------------------------------------------------
interface tspsc_req_if;
  import tspsc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [IDX_FW-1:0]    index_i;
  logic [IDX_FW-1:0]    index_j;
  logic [IDX_FW-1:0]    index_k;
  logic [ENTRY_W-1:0]   entry_value;
  logic [MASK_W-1:0]    set_s;
  logic [MASK_W-1:0]    set_t;

  modport source (
    output valid, req_type, index_i, index_j, index_k, entry_value, set_s, set_t,
    input  ready
  );

  modport sink (
    input  valid, req_type, index_i, index_j, index_k, entry_value, set_s, set_t,
    output ready
  );
endinterface

interface tspsc_rsp_if;
  import tspsc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [IDX_FW-1:0]    elem_index;
  logic [PRODUCT_W-1:0] product_value;
  logic                 splits;
  logic                 last;

  modport source (
    output valid, elem_index, product_value, splits, last,
    input  ready
  );

  modport sink (
    input  valid, elem_index, product_value, splits, last,
    output ready
  );
endinterface

// ----- rtl/tspsc_ram.sv -----
// ----------------------------------------------------------------------------
// tspsc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tspsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/tensor_set_product_split_check.sv -----
// ----------------------------------------------------------------------------
// tensor_set_product_split_check
// Structure-constant store with masked product query and split check.
// ----------------------------------------------------------------------------
// The tensor lives in one RAM, one row per (i,j) pair holding all MAX_RANK
// elements k. An entry write is a read-modify-write of its row; a write
// with an index out of range is dropped. A query scans the pairs of s and t
// under a small sequencer, one step per i outside s and one per (i,j) with i
// in s, and the shared row adder folds one row into the per-element
// accumulators per member pair. With r the rank in use, the scan is followed
// by a drain state, a split check over the members of s, a setup state and
// r result transfers at one per cycle when the sink is ready. The RAM read
// port sets the pace of the scan. No request is taken until the last result
// of a query has been transferred.
`include "tensor_set_product_split_check_assert.svh"

module tensor_set_product_split_check #(
  parameter int MAX_RANK   = tspsc_pkg::MAX_RANK_DEF,
  parameter int VALUE_BITS = tspsc_pkg::VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  tspsc_req_if.sink                        req,
  tspsc_rsp_if.source                      rsp,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tspsc_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tspsc_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tspsc_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready
);
  import tspsc_pkg::*;

  localparam int IDX_W   = $clog2(MAX_RANK);
  localparam int ROW_W   = MAX_RANK * VALUE_BITS;
  localparam int ROWS    = 1 << (2 * IDX_W);
  localparam logic [RANK_REG_W-1:0] RANK_LIMIT = RANK_REG_W'(MAX_RANK);

  // ---------------------------------------------------------------- registers
  logic [RANK_REG_W-1:0] rank_in_use;

  state_t state, state_next;

  logic [IDX_W-1:0]      last_idx;
  logic [IDX_W-1:0]      i, j;
  logic [MAX_RANK-1:0]   s_mask, t_mask;
  logic                  rd_v;
  logic [VALUE_BITS-1:0] acc [MAX_RANK];

  logic                  have_ref;
  logic [VALUE_BITS-1:0] ref_val;
  logic                  split;

  logic [IDX_W-1:0]      wr_k;
  logic [VALUE_BITS-1:0] wr_val;
  logic [2*IDX_W-1:0]    wr_row;

  logic [IDX_W-1:0]      out_k;
  logic [IDX_FW-1:0]     out_elem;
  logic [PRODUCT_W-1:0]  out_val;
  logic                  out_split;
  logic                  out_last;

  // ------------------------------------------------------------ control nets
  logic                  in_xfer, out_xfer, cfg_wr;
  logic                  is_query, wr_in_range;
  logic                  issue, adv_i;
  logic                  ram_we;
  logic [2*IDX_W-1:0]    ram_raddr;
  logic [ROW_W-1:0]      ram_rdata, ram_wdata;
  logic [IDX_W-1:0]      ld_k;
  logic [IDX_W-1:0]      last_idx_next;

  assign in_xfer  = req.valid && req.ready;
  assign out_xfer = rsp.valid && rsp.ready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign is_query = (req.req_type == REQ_QUERY);

  assign wr_in_range = ({1'b0, req.index_i} < RANK_LIMIT) &&
                       ({1'b0, req.index_j} < RANK_LIMIT) &&
                       ({1'b0, req.index_k} < RANK_LIMIT);

  // rank 0 counts as 1, anything above MAX_RANK as MAX_RANK
  always_comb begin
    if (rank_in_use == '0) begin
      last_idx_next = '0;
    end else if (rank_in_use > RANK_LIMIT) begin
      last_idx_next = IDX_W'(MAX_RANK - 1);
    end else begin
      last_idx_next = IDX_W'(rank_in_use - RANK_REG_W'(1));
    end
  end

  // ------------------------------------------------------------- config port
  assign pready = 1'b1;

  always_comb begin
    prdata = '0;
    if (paddr[APB_ADDR_W-1:2] == REG_RANK) begin
      prdata = APB_DATA_W'(rank_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_in_use <= RESET_RANK;
    end else if (cfg_wr && (paddr[APB_ADDR_W-1:2] == REG_RANK)) begin
      rank_in_use <= pwdata[RANK_REG_W-1:0];
    end
  end

  // ---------------------------------------------------------- tensor storage
  tspsc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_tensor (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_row),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // row read in the accept cycle, patched in one lane and written back
  always_comb begin
    for (int k = 0; k < MAX_RANK; k++) begin
      if (IDX_W'(k) == wr_k) begin
        ram_wdata[k*VALUE_BITS +: VALUE_BITS] = wr_val;
      end else begin
        ram_wdata[k*VALUE_BITS +: VALUE_BITS] = ram_rdata[k*VALUE_BITS +: VALUE_BITS];
      end
    end
  end

  // ------------------------------------------------------------- sequencer
  assign adv_i = !s_mask[i] || (j == last_idx);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          if (is_query) begin
            state_next = ST_ACC;
          end else if (wr_in_range) begin
            state_next = ST_WR_MERGE;
          end
        end
      end
      ST_WR_MERGE:  state_next = ST_IDLE;
      ST_ACC: begin
        if (adv_i && (i == last_idx)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:     state_next = ST_SPLIT;
      ST_SPLIT: begin
        if (i == last_idx) begin
          state_next = ST_SPLIT_END;
        end
      end
      ST_SPLIT_END: state_next = ST_OUT;
      ST_OUT: begin
        if (out_xfer && (out_k == last_idx)) begin
          state_next = ST_IDLE;
        end
      end
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    rsp.valid = 1'b0;
    issue     = 1'b0;
    ram_we    = 1'b0;
    ram_raddr = {i, j};
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        ram_raddr = {req.index_i[IDX_W-1:0], req.index_j[IDX_W-1:0]};
      end
      ST_WR_MERGE: ram_we = 1'b1;
      ST_ACC:      issue = s_mask[i] && t_mask[j];
      ST_OUT:      rsp.valid = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rd_v  <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= issue;
    end
  end

  // ---------------------------------------------------------------- datapath
  assign ld_k = (state == ST_SPLIT_END) ? '0 : out_k + IDX_W'(1);

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          wr_k     <= req.index_k[IDX_W-1:0];
          wr_val   <= VALUE_BITS'(req.entry_value);
          wr_row   <= {req.index_i[IDX_W-1:0], req.index_j[IDX_W-1:0]};
          i        <= '0;
          j        <= '0;
          s_mask   <= req.set_s[MAX_RANK-1:0];
          t_mask   <= req.set_t[MAX_RANK-1:0];
          last_idx <= last_idx_next;
          have_ref <= 1'b0;
          split    <= 1'b0;
          if (is_query) begin
            for (int k = 0; k < MAX_RANK; k++) begin
              acc[k] <= '0;
            end
          end
        end
      end
      ST_ACC: begin
        if (adv_i) begin
          i <= i + IDX_W'(1);
          j <= '0;
        end else begin
          j <= j + IDX_W'(1);
        end
      end
      ST_DRAIN: i <= '0;
      ST_SPLIT: begin
        i <= i + IDX_W'(1);
        if (s_mask[i]) begin
          if (!have_ref) begin
            ref_val  <= acc[i];
            have_ref <= 1'b1;
          end else if (acc[i] != ref_val) begin
            split <= 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    // shared row adder: every lane wraps on its own
    if (rd_v) begin
      for (int k = 0; k < MAX_RANK; k++) begin
        acc[k] <= acc[k] + ram_rdata[k*VALUE_BITS +: VALUE_BITS];
      end
    end

    if ((state == ST_SPLIT_END) || (out_xfer && (out_k != last_idx))) begin
      out_k     <= ld_k;
      out_elem  <= IDX_FW'(ld_k);
      out_val   <= acc[ld_k][PRODUCT_W-1:0];
      out_last  <= (ld_k == last_idx);
      out_split <= (ld_k == last_idx) && split;
    end
  end

  assign rsp.elem_index    = out_elem;
  assign rsp.product_value = out_val;
  assign rsp.splits        = out_split;
  assign rsp.last          = out_last;

  // -------------------------------------------------------------- assertions
  `TSPSC_ASSERT_IMP(a_out_blocks_req, rsp.valid, !req.ready, "request taken during result run")
  `TSPSC_ASSERT_IMP(a_row_in_scan, rd_v, (state == ST_ACC) || (state == ST_DRAIN), "row add outside scan")
  `TSPSC_ASSERT_NXT(a_last_frees, out_xfer && rsp.last, req.ready, "not idle after last transfer")

endmodule
